[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gdw_pkg.sv]
`default_nettype none

package gdw_pkg;

  localparam int unsigned MAP_ROWS  = 64;
  localparam int unsigned MAP_COLS  = 64;
  localparam int unsigned MAX_STEPS = 128;

  localparam int unsigned MAP_CELLS = MAP_ROWS * MAP_COLS;
  localparam int unsigned ADDR_W    = $clog2(MAP_CELLS);
  localparam int unsigned CNT_W     = $clog2(MAX_STEPS + 1);

  localparam int unsigned POS_W  = 6;
  localparam int unsigned Q_W    = 32;
  localparam int unsigned CODE_W = 8;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_WALL  = 2'd0,
    ST_LEFT  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_WRITE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [CODE_W-1:0]  value;
    logic [Q_W-1:0]     side_x;
    logic [Q_W-1:0]     side_y;
    logic [Q_W-1:0]     delta_x;
    logic [Q_W-1:0]     delta_y;
    logic signed [1:0]  step_x;
    logic signed [1:0]  step_y;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    face_e            face;
    logic [Q_W-1:0]   side_x;
    logic [Q_W-1:0]   side_y;
    status_e          status;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic step_en;
    logic fin;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic start_oob;
    logic stop;
  } stat_t;

endpackage

`default_nettype wire

[rtl/gdw_ctrl.sv]
`default_nettype none

module gdw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire gdw_pkg::op_e  op_i,
  input  wire logic          out_busy_i,
  input  wire gdw_pkg::stat_t stat_i,
  output gdw_pkg::cmd_t      cmd_o,
  output logic               s_ready_o
);
  import gdw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          if (op_i == OP_WRITE || stat_i.start_oob) state_d = S_FIN;
          else                                      state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.stop) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_busy_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      S_WALK: cmd_o.step_en = 1'b1;
      S_FIN: begin
        cmd_o.fin      = 1'b1;
        cmd_o.out_load = !out_busy_i;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/gdw_datapath.sv]
`default_nettype none

module gdw_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire gdw_pkg::item_t item_i,
  input  wire gdw_pkg::cmd_t  cmd_i,
  output gdw_pkg::stat_t      stat_o,
  output gdw_pkg::res_t       res_o
);
  import gdw_pkg::*;

  localparam int unsigned POS_X_W = POS_W + 2;
  localparam logic [Q_W-1:0]    Q_MAX      = '1;
  localparam logic [CODE_W-1:0] WALL_ABOVE = 8'h30;
  localparam logic [CODE_W-1:0] BLANK_CODE = 8'h20;

  function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [Q_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[Q_W] ? Q_MAX : s[Q_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] r,
                                                input logic [POS_W-1:0] c);
    return ADDR_W'(32'(r) * MAP_COLS + 32'(c));
  endfunction

  logic [CODE_W-1:0] mem [MAP_CELLS];
  logic [CODE_W-1:0] rdata_q;

  logic [POS_W-1:0]  row_q, col_q;
  logic [Q_W-1:0]    sx_q, sy_q, dx_q, dy_q;
  logic              neg_x_q, neg_y_q;
  face_e             face_q;
  status_e           status_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              entered_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // one walk step, evaluated every cycle
  logic               go_x, wall_now, at_limit, nxt_oob;
  logic [POS_X_W-1:0] nr_x, nc_x;
  logic               oob_r, oob_c;
  logic [POS_W-1:0]   row_nxt, col_nxt;
  logic [ADDR_W-1:0]  rd_addr;
  logic               in_map;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CODE_W-1:0]  wr_data;

  always_comb begin
    go_x     = sx_q < sy_q;
    wall_now = entered_q && (rdata_q > WALL_ABOVE || rdata_q == BLANK_CODE);
    at_limit = 32'(cnt_q) == MAX_STEPS;
    nr_x     = {2'b00, row_q} + (neg_x_q ? '1 : POS_X_W'(1));
    nc_x     = {2'b00, col_q} + (neg_y_q ? '1 : POS_X_W'(1));
    oob_r    = nr_x[POS_X_W-1] || 32'(nr_x) >= MAP_ROWS;
    oob_c    = nc_x[POS_X_W-1] || 32'(nc_x) >= MAP_COLS;
    nxt_oob  = go_x ? oob_r : oob_c;
    row_nxt  = go_x ? nr_x[POS_W-1:0] : row_q;
    col_nxt  = go_x ? col_q : nc_x[POS_W-1:0];
    rd_addr  = addr_of(row_nxt, col_nxt);
    in_map   = 32'(item_i.row) < MAP_ROWS && 32'(item_i.col) < MAP_COLS;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_q;
    wr_data = '0;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.accept && item_i.op == OP_WRITE && in_map) begin
      wr_en   = 1'b1;
      wr_addr = addr_of(item_i.row, item_i.col);
      wr_data = item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      entered_q  <= 1'b0;
      cnt_q      <= '0;
      status_q   <= ST_WRITE;
    end else begin
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (cmd_i.accept) begin
        entered_q <= 1'b0;
        cnt_q     <= '0;
        if (item_i.op == OP_WRITE) status_q <= ST_WRITE;
        else if (!in_map)          status_q <= ST_LEFT;
        else                       status_q <= ST_WALL;
      end else if (cmd_i.step_en) begin
        if (wall_now) begin
          status_q <= ST_WALL;
        end else if (at_limit) begin
          status_q <= ST_LIMIT;
        end else if (nxt_oob) begin
          status_q <= ST_LEFT;
        end else begin
          cnt_q     <= cnt_q + CNT_W'(1);
          entered_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q   <= item_i.row;
      col_q   <= item_i.col;
      face_q  <= FACE_NORTH;
      dx_q    <= item_i.delta_x;
      dy_q    <= item_i.delta_y;
      neg_x_q <= item_i.step_x[1];
      neg_y_q <= item_i.step_y[1];
      if (item_i.op == OP_WRITE) begin
        sx_q <= '0;
        sy_q <= '0;
      end else begin
        sx_q <= item_i.side_x;
        sy_q <= item_i.side_y;
      end
    end else if (cmd_i.step_en && !wall_now && !at_limit) begin
      if (go_x) begin
        sx_q   <= sat_add(sx_q, dx_q);
        face_q <= neg_x_q ? FACE_SOUTH : FACE_NORTH;
      end else begin
        sy_q   <= sat_add(sy_q, dy_q);
        face_q <= neg_y_q ? FACE_EAST : FACE_WEST;
      end
      if (!nxt_oob) begin
        row_q <= row_nxt;
        col_q <= col_nxt;
      end
    end
  end

  assign stat_o.clr_last  = 32'(clr_addr_q) == MAP_CELLS - 1;
  assign stat_o.start_oob = !in_map;
  assign stat_o.stop      = wall_now || at_limit || nxt_oob;

  assign res_o.row    = row_q;
  assign res_o.col    = col_q;
  assign res_o.face   = face_q;
  assign res_o.side_x = sx_q;
  assign res_o.side_y = sy_q;
  assign res_o.status = status_q;

endmodule

`default_nettype wire

[rtl/grid_dda_ray_walk_unit.sv]
`default_nettype none
// Grid ray walk by DDA over a 64 x 64 character map held in one on-chip RAM
// (one write port, one registered read port). After reset the block sweeps the
// map to zero, one cell a clock, and takes no item until the sweep is done.
// A write item (tuser = 0) stores one cell, and its status 3 result enters the
// output register once that register is free. A cast item (tuser = 1) walks
// cell by cell, stepping along X when side_x < side_y and along Y otherwise,
// adding the per-cell delta with saturation at 0xFFFFFFFF; it stops on a cell
// above '0' or equal to space, on leaving the grid (the last inside cell is
// reported) or after 128 steps. The start cell is never tested. A cast
// enters one cell per clock: the single read port of the map fetches each cell
// as it is entered, and the wall test of that cell overlaps the next step. The
// stop decision then moves the controller to its finish state, which loads the
// result register once it is free. One item is in work at a time; the next
// item is taken while the previous result still waits in the output register.
`include "assert_macros.svh"

module grid_dda_ray_walk_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // row[5:0] col[11:6] value[19:12] side_x[51:20] side_y[83:52]
  // delta_x[115:84] delta_y[147:116] step_x[149:148] step_y[151:150]
  input  wire logic [gdw_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // operation[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // hit_row[5:0] hit_col[11:6] face[13:12] final_side_x[45:14]
  // final_side_y[77:46], zero fill [79:78]
  output logic [gdw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);
  import gdw_pkg::*;

  item_t item;
  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  res_t  res_q;
  logic  m_valid_q;
  logic  out_busy;

  // unpack the input item
  assign item.op      = op_e'(s_axis_tuser[0]);
  assign item.row     = s_axis_tdata[5:0];
  assign item.col     = s_axis_tdata[11:6];
  assign item.value   = s_axis_tdata[19:12];
  assign item.side_x  = s_axis_tdata[51:20];
  assign item.side_y  = s_axis_tdata[83:52];
  assign item.delta_x = s_axis_tdata[115:84];
  assign item.delta_y = s_axis_tdata[147:116];
  assign item.step_x  = s_axis_tdata[149:148];
  assign item.step_y  = s_axis_tdata[151:150];

  // result register stays full until the far side takes it
  assign out_busy = m_valid_q && !m_axis_tready;

  gdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .op_i       (item.op),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .s_ready_o  (s_axis_tready)
  );

  gdw_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) res_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.side_y, res_q.side_x, res_q.face,
                          res_q.col, res_q.row};
  assign m_axis_tuser  = res_q.status;

  // result only goes into a free or draining register
  `ASSERT_PROP(a_load_free, !cmd.out_load || !m_valid_q || m_axis_tready,
               "result loaded over an untaken result")
  // a map write finishes straight away
  `ASSERT_NEXT(a_write_fin, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_WRITE,
               cmd.fin, "write item did not finish in one cycle")
  // walking and taking items never overlap
  `ASSERT_PROP(a_walk_busy, !(cmd.step_en && s_axis_tready),
               "item taken during a walk")

endmodule

`default_nettype wire
